// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the span generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RRSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset cycles included.
`define RRSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rrsg_pkg.sv =====
// Shared constants and types of the rounded rectangle span generator.
package rrsg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CRD_W          = 12;
  localparam int Y_W            = 13;
  localparam int COL_W          = 32;
  localparam int RAD_W          = 8;
  localparam int BRD_W          = 7;
  localparam int SQ_W           = 16;
  localparam int SQ_STEPS       = 8;
  localparam int EDGE_W         = 15;
  localparam int SPANS_MAX      = 3;
  localparam int ACCEPT_GAP     = 3;
  localparam int RECIP3_SH      = 11;

  localparam logic [RAD_W-1:0] RASTER_RST = 8'd24;
  localparam logic [COL_W-1:0] BLACK_ARGB = 32'hFF00_0000;
  localparam logic [BRD_W-1:0] MIN_BORDER = 7'd2;
  // Rounded-up 2^11 / 3; exact floor division by three for values below 2048.
  localparam logic [10:0]      RECIP3     = 11'd683;

  typedef enum logic [1:0] {
    SPAN_LEFT,
    SPAN_FILL,
    SPAN_RIGHT
  } span_sel_t;

  // Per-row data that rides alongside the square root lanes.
  typedef struct packed {
    logic [CRD_W-1:0] left;
    logic [CRD_W-1:0] right;
    logic [BRD_W-1:0] bord;
    logic [RAD_W-1:0] rad_o;
    logic [RAD_W-1:0] rad_i;
    logic [Y_W-1:0]   span_y;
    logic [COL_W-1:0] fill;
    logic [COL_W-1:0] bcol;
    logic             use_o;
    logic             use_i;
    logic             border_row;
  } rrsg_row_t;

  // What one square root cell hands to the next.
  typedef struct packed {
    logic            vld;
    logic [SQ_W-1:0] x_o;
    logic [SQ_W-1:0] res_o;
    logic [SQ_W-1:0] x_i;
    logic [SQ_W-1:0] res_i;
    rrsg_row_t       row;
  } rrsg_cell_t;

endpackage

// ===== rtl/rrsg_front.sv =====
// Setup pipeline: radius, border width, corner distance and squared radicands.
module rrsg_front import rrsg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [RAD_W-1:0] raster,
  input  logic [CRD_W-1:0] in_rect_left,
  input  logic [CRD_W-1:0] in_rect_right,
  input  logic [CRD_W-1:0] in_rect_top,
  input  logic [CRD_W-1:0] in_rect_height,
  input  logic [CRD_W-1:0] in_row_index,
  input  logic [COL_W-1:0] in_fill_color,
  input  logic [COL_W-1:0] in_border_color,
  input  logic             in_border_given,
  output rrsg_cell_t       head
);

  localparam int NSTG = 5;

  typedef struct packed {
    logic [CRD_W-1:0] h;
    logic [CRD_W-1:0] y;
    logic [RAD_W-1:0] rast;
    logic [RAD_W-1:0] corner_d;
    logic [SQ_W-1:0]  sq_o;
    logic [SQ_W-1:0]  sq_i;
    logic [SQ_W-1:0]  sq_d;
    rrsg_row_t        row;
  } front_t;

  front_t     stg_r   [NSTG];
  front_t     stg_nxt [NSTG];
  logic       vld_r   [NSTG];
  logic       vld_nxt [NSTG];
  rrsg_cell_t head_r;
  rrsg_cell_t head_nxt;

  logic [20:0]      hprod;
  logic [18:0]      bprod;
  logic [RAD_W-1:0] hd3;
  logic [BRD_W-1:0] bq;
  logic             short_btn;
  logic             top_c;
  logic             bot_c;
  logic [Y_W-1:0]   yr;
  logic [Y_W-1:0]   yb;
  logic [Y_W-1:0]   ydif;

  always_comb begin
    // Stage 0: capture the transaction and pick the border color.
    stg_nxt[0]                = '0;
    stg_nxt[0].h              = in_rect_height;
    stg_nxt[0].y              = in_row_index;
    stg_nxt[0].rast           = raster;
    stg_nxt[0].row.left       = in_rect_left;
    stg_nxt[0].row.right      = in_rect_right;
    stg_nxt[0].row.span_y     = Y_W'(in_rect_top) + Y_W'(in_row_index);
    stg_nxt[0].row.fill       = in_fill_color;
    stg_nxt[0].row.bcol       = in_border_given ? in_border_color : BLACK_ARGB;
    vld_nxt[0]                = fire && (in_row_index < in_rect_height);

    // Stage 1: outer radius, a third of the height for short buttons.
    hprod      = 21'(stg_r[0].h[9:0]) * 21'(RECIP3);
    hd3        = hprod[RECIP3_SH +: RAD_W];
    short_btn  = Y_W'(stg_r[0].h) <= Y_W'({stg_r[0].rast, 1'b0});
    stg_nxt[1] = stg_r[0];
    stg_nxt[1].row.rad_o = short_btn ? hd3 : stg_r[0].rast;
    vld_nxt[1] = vld_r[0];

    // Stage 2: border width and inner radius.
    bprod      = 19'(stg_r[1].row.rad_o) * 19'(RECIP3);
    bq         = bprod[RECIP3_SH +: BRD_W];
    stg_nxt[2] = stg_r[1];
    stg_nxt[2].row.bord  = (bq < MIN_BORDER) ? MIN_BORDER : bq;
    stg_nxt[2].row.rad_i = stg_r[1].row.rad_o - RAD_W'(stg_nxt[2].row.bord);
    vld_nxt[2] = vld_r[1];

    // Stage 3: corner classification. The inner arc uses the same distance
    // from the corner center as the outer arc.
    top_c = stg_r[2].y < CRD_W'(stg_r[2].row.rad_o);
    yr    = Y_W'(stg_r[2].y) + Y_W'(stg_r[2].row.rad_o);
    yb    = Y_W'(stg_r[2].y) + Y_W'(stg_r[2].row.bord);
    bot_c = !top_c && (yr > Y_W'(stg_r[2].h));
    ydif  = yr - Y_W'(stg_r[2].h);
    stg_nxt[3] = stg_r[2];
    stg_nxt[3].corner_d = top_c ? (stg_r[2].row.rad_o - stg_r[2].y[RAD_W-1:0])
                                : ydif[RAD_W-1:0];
    stg_nxt[3].row.use_o = top_c || bot_c;
    stg_nxt[3].row.use_i = top_c ? (stg_r[2].y >= CRD_W'(stg_r[2].row.bord))
                                 : (bot_c && (yb <= Y_W'(stg_r[2].h)));
    stg_nxt[3].row.border_row = (stg_r[2].y < CRD_W'(stg_r[2].row.bord)) ||
                                (yb >= Y_W'(stg_r[2].h));
    vld_nxt[3] = vld_r[2];

    // Stage 4: squares of both radii and of the distance.
    stg_nxt[4]      = stg_r[3];
    stg_nxt[4].sq_o = SQ_W'(stg_r[3].row.rad_o) * SQ_W'(stg_r[3].row.rad_o);
    stg_nxt[4].sq_i = SQ_W'(stg_r[3].row.rad_i) * SQ_W'(stg_r[3].row.rad_i);
    stg_nxt[4].sq_d = SQ_W'(stg_r[3].corner_d) * SQ_W'(stg_r[3].corner_d);
    vld_nxt[4]      = vld_r[3];

    // Radicands for the root chain; unused lanes run on zero.
    head_nxt       = '0;
    head_nxt.vld   = vld_r[4];
    head_nxt.row   = stg_r[4].row;
    head_nxt.x_o   = stg_r[4].row.use_o ? (stg_r[4].sq_o - stg_r[4].sq_d) : '0;
    head_nxt.x_i   = stg_r[4].row.use_i ? (stg_r[4].sq_i - stg_r[4].sq_d) : '0;
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign head = head_r;

endmodule

// ===== rtl/rrsg_sqrt_cell.sv =====
// One digit step of the integer square root, for the outer and inner arcs.
module rrsg_sqrt_cell import rrsg_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rrsg_cell_t cin,
  output rrsg_cell_t cout
);

  localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1 << (2 * (SQ_STEPS - 1 - STEP)));

  rrsg_cell_t cout_r;
  rrsg_cell_t cout_nxt;

  // Returns {remainder, partial root} after one digit.
  function automatic logic [2*SQ_W-1:0] root_step(input logic [SQ_W-1:0] x,
                                                  input logic [SQ_W-1:0] res);
    logic [SQ_W:0] trial;
    logic [SQ_W:0] rem;
    logic [SQ_W:0] nres;
    trial = {1'b0, res} + BIT;
    if ({1'b0, x} >= trial) begin
      rem  = {1'b0, x} - trial;
      nres = ({1'b0, res} >> 1) + BIT;
      return {rem[SQ_W-1:0], nres[SQ_W-1:0]};
    end
    return {x, res >> 1};
  endfunction

  always_comb begin
    cout_nxt = cin;
    {cout_nxt.x_o, cout_nxt.res_o} = root_step(cin.x_o, cin.res_o);
    {cout_nxt.x_i, cout_nxt.res_i} = root_step(cin.x_i, cin.res_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r <= '0;
    end else begin
      cout_r <= cout_nxt;
    end
  end

  assign cout = cout_r;

endmodule

// ===== rtl/rrsg_span_emit.sv =====
// Edge assembly and span sequencer: one or three spans per row, one per cycle.
module rrsg_span_emit import rrsg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rrsg_cell_t       tail,
  output logic             out_valid,
  output logic [CRD_W-1:0] out_span_x_start,
  output logic [CRD_W-1:0] out_span_x_end,
  output logic [Y_W-1:0]   out_span_y,
  output logic [COL_W-1:0] out_span_color,
  output logic             out_last_span
);

  localparam int MAXC = (1 << COORD_BITS) - 1;

  logic [EDGE_W-1:0] l1_r, r1_r, l2_r, r2_r;
  logic [EDGE_W-1:0] l1_nxt, r1_nxt, l2_nxt, r2_nxt;
  logic [Y_W-1:0]    y_r;
  logic [COL_W-1:0]  fill_r, bcol_r;
  logic              brd_r;
  logic [1:0]        cnt_r, cnt_nxt;
  span_sel_t         sel_r, sel_nxt;

  logic [RAD_W-1:0]  t_o, t_i;
  logic              emit;
  logic [EDGE_W-1:0] xs, xe;
  logic [COL_W-1:0]  col;
  logic              last;

  logic              out_valid_r;
  logic [CRD_W-1:0]  xs_r, xe_r;
  logic [Y_W-1:0]    oy_r;
  logic [COL_W-1:0]  col_r;
  logic              last_r;

  // Signed edge clamped to the screen, then cut to the port width.
  function automatic logic [CRD_W-1:0] clamp_x(input logic [EDGE_W-1:0] v);
    if (v[EDGE_W-1]) begin
      return '0;
    end
    if (int'(v) > MAXC) begin
      return CRD_W'(MAXC);
    end
    return v[CRD_W-1:0];
  endfunction

  always_comb begin
    t_o    = tail.row.use_o ? (tail.row.rad_o - tail.res_o[RAD_W-1:0]) : '0;
    t_i    = tail.row.use_i ? (tail.row.rad_i - tail.res_i[RAD_W-1:0]) : '0;
    l1_nxt = EDGE_W'(tail.row.left) + EDGE_W'(t_o);
    r1_nxt = EDGE_W'(tail.row.right) - EDGE_W'(t_o);
    l2_nxt = EDGE_W'(tail.row.left) + EDGE_W'(tail.row.bord) + EDGE_W'(t_i);
    r2_nxt = EDGE_W'(tail.row.right) - EDGE_W'(tail.row.bord) - EDGE_W'(t_i);
  end

  always_comb begin
    emit = cnt_r != 2'd0;
    xs   = l1_r;
    xe   = r1_r;
    col  = bcol_r;
    last = 1'b1;
    if (!brd_r) begin
      case (sel_r)
        SPAN_LEFT: begin
          xe   = l2_r - EDGE_W'(1);
          last = 1'b0;
        end
        SPAN_FILL: begin
          xs   = l2_r;
          xe   = r2_r;
          col  = fill_r;
          last = 1'b0;
        end
        SPAN_RIGHT: begin
          xs = r2_r + EDGE_W'(1);
        end
        default: begin
          xs = l1_r;
        end
      endcase
    end

    // A new row lands on the same edge as the previous row's last span.
    if (tail.vld) begin
      cnt_nxt = tail.row.border_row ? 2'd1 : 2'(SPANS_MAX);
      sel_nxt = SPAN_LEFT;
    end else if (emit) begin
      cnt_nxt = cnt_r - 2'd1;
      case (sel_r)
        SPAN_LEFT: sel_nxt = SPAN_FILL;
        SPAN_FILL: sel_nxt = SPAN_RIGHT;
        default:   sel_nxt = SPAN_LEFT;
      endcase
    end else begin
      cnt_nxt = cnt_r;
      sel_nxt = sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      l1_r   <= l1_nxt;
      r1_r   <= r1_nxt;
      l2_r   <= l2_nxt;
      r2_r   <= r2_nxt;
      y_r    <= tail.row.span_y;
      fill_r <= tail.row.fill;
      bcol_r <= tail.row.bcol;
      brd_r  <= tail.row.border_row;
    end
    xs_r   <= clamp_x(xs);
    xe_r   <= clamp_x(xe);
    oy_r   <= y_r;
    col_r  <= col;
    last_r <= last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      sel_r       <= SPAN_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_x_start = xs_r;
  assign out_span_x_end   = xe_r;
  assign out_span_y       = oy_r;
  assign out_span_color   = col_r;
  assign out_last_span    = last_r;

endmodule

// ===== rtl/rounded_rect_span_generator.sv =====
// Top level of the rounded rectangle span generator.
//
//   Channel   Handshake            Payload
//   ------    ---------            -------
//   input     start, busy          in_rect_*, in_row_index, in_*_color, in_border_given
//   result    out_valid (strobe)   out_span_x_start/_end, out_span_y, out_span_color,
//                                  out_last_span
//   config    cfg_wr_en            cfg_wr_data (raster size)
//
// A transaction is taken only while busy is low; busy rises after each accept
// and holds off new ones for the time the span sequencer needs for a
// three-span row. A row passes five setup stages, the chain input register,
// eight square root cells and two sequencer registers before its first span is
// on the result ports, and the rest follow on consecutive cycles. Rows below
// the rectangle give no span. Reset is synchronous, clears the valid flags and
// returns the raster size to 24. Results cannot be stalled and are never dropped.
module rounded_rect_span_generator import rrsg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CRD_W-1:0] in_rect_left,
  input  logic [CRD_W-1:0] in_rect_right,
  input  logic [CRD_W-1:0] in_rect_top,
  input  logic [CRD_W-1:0] in_rect_height,
  input  logic [CRD_W-1:0] in_row_index,
  input  logic [COL_W-1:0] in_fill_color,
  input  logic [COL_W-1:0] in_border_color,
  input  logic             in_border_given,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data,
  output logic             out_valid,
  output logic [CRD_W-1:0] out_span_x_start,
  output logic [CRD_W-1:0] out_span_x_end,
  output logic [Y_W-1:0]   out_span_y,
  output logic [COL_W-1:0] out_span_color,
  output logic             out_last_span
);

  logic [RAD_W-1:0] raster_r, raster_nxt;
  logic [1:0]       cool_r, cool_nxt;
  logic             fire;
  rrsg_cell_t       chain [SQ_STEPS+1];

  assign fire = start && !busy;
  assign busy = cool_r != 2'd0;

  always_comb begin
    raster_nxt = cfg_wr_en ? cfg_wr_data : raster_r;
    if (fire) begin
      cool_nxt = 2'(ACCEPT_GAP - 1);
    end else if (cool_r != 2'd0) begin
      cool_nxt = cool_r - 2'd1;
    end else begin
      cool_nxt = cool_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_r <= RASTER_RST;
      cool_r   <= 2'd0;
    end else begin
      raster_r <= raster_nxt;
      cool_r   <= cool_nxt;
    end
  end

  rrsg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .raster          (raster_r),
    .in_rect_left    (in_rect_left),
    .in_rect_right   (in_rect_right),
    .in_rect_top     (in_rect_top),
    .in_rect_height  (in_rect_height),
    .in_row_index    (in_row_index),
    .in_fill_color   (in_fill_color),
    .in_border_color (in_border_color),
    .in_border_given (in_border_given),
    .head            (chain[0])
  );

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
    rrsg_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cin   (chain[k]),
      .cout  (chain[k+1])
    );
  end

  rrsg_span_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .tail             (chain[SQ_STEPS]),
    .out_valid        (out_valid),
    .out_span_x_start (out_span_x_start),
    .out_span_x_end   (out_span_x_end),
    .out_span_y       (out_span_y),
    .out_span_color   (out_span_color),
    .out_last_span    (out_last_span)
  );

endmodule

// ===== rtl/rrsg_checker.sv =====
// Port-level checker for the span generator and its bind statement.
`include "assert_macros.svh"

module rrsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [12:0] out_span_y,
  input logic        out_last_span
);

  // After a transaction is taken, busy holds off a new one for the accept gap.
  `RRSG_ASSERT(a_accept_gap, (start && !busy) |=> busy ##1 busy, "accept gap too short")

  // Spans of one row come back to back until the last one.
  `RRSG_ASSERT(a_row_burst, (out_valid && !out_last_span) |=> out_valid, "row burst broken")

  // All spans of one row share the same screen row.
  `RRSG_ASSERT(a_row_y, (out_valid && !out_last_span) |=> $stable(out_span_y), "span row changed")

  // Reset leaves no strobe and no busy behind.
  `RRSG_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !busy), "activity after reset")

endmodule

bind rounded_rect_span_generator rrsg_checker u_rrsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_span_y    (out_span_y),
  .out_last_span (out_last_span)
);

// ===== tb/rounded_rect_span_generator_checker.sv =====
// Checker that predicts and compares the spans of the rounded rectangle span generator.
`timescale 1ns / 1ps

module rounded_rect_span_generator_checker import rrsg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [CRD_W-1:0] in_rect_left,
  input  logic [CRD_W-1:0] in_rect_right,
  input  logic [CRD_W-1:0] in_rect_top,
  input  logic [CRD_W-1:0] in_rect_height,
  input  logic [CRD_W-1:0] in_row_index,
  input  logic [COL_W-1:0] in_fill_color,
  input  logic [COL_W-1:0] in_border_color,
  input  logic             in_border_given,
  input  logic             cfg_wr_en,
  input  logic [RAD_W-1:0] cfg_wr_data,
  input  logic             out_valid,
  input  logic [CRD_W-1:0] out_span_x_start,
  input  logic [CRD_W-1:0] out_span_x_end,
  input  logic [Y_W-1:0]   out_span_y,
  input  logic [COL_W-1:0] out_span_color,
  input  logic             out_last_span,
  output int               mismatch_count,
  output int               spans_pending
);

  typedef struct {
    logic [CRD_W-1:0] x_start;
    logic [CRD_W-1:0] x_end;
    logic [Y_W-1:0]   y;
    logic [COL_W-1:0] color;
    logic             last;
  } span_t;

  span_t            pending_spans[$];
  logic [RAD_W-1:0] raster_size;

  function automatic longint floor_sqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    if (v <= 0) return 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint corner_inset(input longint rad, input longint d);
    return rad - floor_sqrt(rad * rad - d * d);
  endfunction

  function automatic logic [CRD_W-1:0] clamp_x(input longint v);
    longint top_x;
    top_x = (longint'(1) << CRD_W) - 1;
    if (v < 0) v = 0;
    if (v > top_x) v = top_x;
    return v[CRD_W-1:0];
  endfunction

  function automatic void push_span(input longint xs, input longint xe,
                                    input logic [Y_W-1:0] y,
                                    input logic [COL_W-1:0] color, input logic last);
    span_t s;
    s.x_start = clamp_x(xs);
    s.x_end   = clamp_x(xe);
    s.y       = y;
    s.color   = color;
    s.last    = last;
    pending_spans.push_back(s);
  endfunction

  // Works out the spans of one row and queues them in drawing order.
  function automatic void row_spans(input logic [RAD_W-1:0] rs);
    longint left, right, h, y, rad, bord, rad_in, l1, l2, r1, r2, t;
    logic [Y_W-1:0]   sy;
    logic [COL_W-1:0] bcol;
    left  = longint'(in_rect_left);
    right = longint'(in_rect_right);
    h     = longint'(in_rect_height);
    y     = longint'(in_row_index);
    sy    = {1'b0, in_rect_top} + {1'b0, in_row_index};
    bcol  = in_border_given ? in_border_color : BLACK_ARGB;
    if (y >= h) return;
    rad = longint'(rs);
    // Short buttons take a third of the height as the corner radius.
    if (h <= 2 * rad) rad = h / 3;
    bord = rad / 3;
    if (bord < 2) bord = 2;
    rad_in = rad - bord;
    l1 = left;
    r1 = right;
    l2 = left + bord;
    r2 = right - bord;
    if (y < rad) begin
      t = corner_inset(rad, rad - y);
      l1 += t;
      r1 -= t;
      if (y >= bord) begin
        t = corner_inset(rad_in, rad_in - (y - bord));
        l2 += t;
        r2 -= t;
      end
    end else if (y > h - rad) begin
      t = corner_inset(rad, y - h + rad);
      l1 += t;
      r1 -= t;
      if (y <= h - bord) begin
        t = corner_inset(rad_in, rad_in - (h - bord - y));
        l2 += t;
        r2 -= t;
      end
    end
    if (y < bord || y >= h - bord) begin
      push_span(l1, r1, sy, bcol, 1'b1);
    end else begin
      push_span(l1, l2 - 1, sy, bcol, 1'b0);
      push_span(l2, r2, sy, in_fill_color, 1'b0);
      push_span(r2 + 1, r1, sy, bcol, 1'b1);
    end
  endfunction

  initial begin
    mismatch_count = 0;
    spans_pending  = 0;
    raster_size    = RASTER_RST;
  end

  always @(posedge clk) begin
    span_t want;
    // A row is predicted with the raster size in force before this edge.
    if (rst_n && start && !busy) row_spans(raster_size);
    if (rst_n && out_valid) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span: x %0d..%0d y %0d", out_span_x_start, out_span_x_end,
               out_span_y);
        mismatch_count++;
      end else begin
        want = pending_spans.pop_front();
        if (out_span_x_start !== want.x_start) begin
          $error("span_x_start: expected %0d, got %0d", want.x_start, out_span_x_start);
          mismatch_count++;
        end
        if (out_span_x_end !== want.x_end) begin
          $error("span_x_end: expected %0d, got %0d", want.x_end, out_span_x_end);
          mismatch_count++;
        end
        if (out_span_y !== want.y) begin
          $error("span_y: expected %0d, got %0d", want.y, out_span_y);
          mismatch_count++;
        end
        if (out_span_color !== want.color) begin
          $error("span_color: expected %h, got %h", want.color, out_span_color);
          mismatch_count++;
        end
        if (out_last_span !== want.last) begin
          $error("last_span: expected %0d, got %0d", want.last, out_last_span);
          mismatch_count++;
        end
      end
    end
    if (!rst_n) raster_size = RASTER_RST;
    else if (cfg_wr_en) raster_size = cfg_wr_data;
    spans_pending = pending_spans.size();
  end

endmodule

// ===== tb/rounded_rect_span_generator_tb.sv =====
// Testbench top that drives rows and raster sizes into the span generator.
`timescale 1ns / 1ps

module rounded_rect_span_generator_tb import rrsg_pkg::*;;

  localparam int IDLE_LIMIT  = 1000;
  localparam int SETTLE_CYC  = 24;
  localparam int ROWS_PER_RS = 40;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [CRD_W-1:0] in_rect_left;
  logic [CRD_W-1:0] in_rect_right;
  logic [CRD_W-1:0] in_rect_top;
  logic [CRD_W-1:0] in_rect_height;
  logic [CRD_W-1:0] in_row_index;
  logic [COL_W-1:0] in_fill_color;
  logic [COL_W-1:0] in_border_color;
  logic             in_border_given;
  logic             cfg_wr_en;
  logic [RAD_W-1:0] cfg_wr_data;
  logic             out_valid;
  logic [CRD_W-1:0] out_span_x_start;
  logic [CRD_W-1:0] out_span_x_end;
  logic [Y_W-1:0]   out_span_y;
  logic [COL_W-1:0] out_span_color;
  logic             out_last_span;
  int               mismatch_count;
  int               spans_pending;
  int               idle_cycles;
  logic             no_gaps;
  int               raster_now;

  rounded_rect_span_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_rect_left(in_rect_left), .in_rect_right(in_rect_right),
    .in_rect_top(in_rect_top), .in_rect_height(in_rect_height),
    .in_row_index(in_row_index), .in_fill_color(in_fill_color),
    .in_border_color(in_border_color), .in_border_given(in_border_given),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_span_x_start(out_span_x_start),
    .out_span_x_end(out_span_x_end), .out_span_y(out_span_y),
    .out_span_color(out_span_color), .out_last_span(out_last_span)
  );

  rounded_rect_span_generator_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_rect_left(in_rect_left), .in_rect_right(in_rect_right),
    .in_rect_top(in_rect_top), .in_rect_height(in_rect_height),
    .in_row_index(in_row_index), .in_fill_color(in_fill_color),
    .in_border_color(in_border_color), .in_border_given(in_border_given),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_span_x_start(out_span_x_start),
    .out_span_x_end(out_span_x_end), .out_span_y(out_span_y),
    .out_span_color(out_span_color), .out_last_span(out_last_span),
    .mismatch_count(mismatch_count), .spans_pending(spans_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Ends the run when no transaction of any kind has happened for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_row(input int left, input int right, input int top, input int h,
                          input int y, input logic [COL_W-1:0] fill,
                          input logic [COL_W-1:0] bcol, input logic given);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_rect_left    = left[CRD_W-1:0];
    in_rect_right   = right[CRD_W-1:0];
    in_rect_top     = top[CRD_W-1:0];
    in_rect_height  = h[CRD_W-1:0];
    in_row_index    = y[CRD_W-1:0];
    in_fill_color   = fill;
    in_border_color = bcol;
    in_border_given = given;
    start           = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Holds the sender off until every span has come and the pipe has emptied.
  task automatic settle();
    start = 1'b0;
    while (spans_pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_raster(input int rs);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = rs[RAD_W-1:0];
    raster_now  = rs;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_row();
    int h, y, left, right, reach;
    case ($urandom_range(0, 9))
      0:       h = $urandom_range(0, 4095);
      1:       h = $urandom_range(0, 12);
      2:       h = 2 * raster_now + $urandom_range(0, 2) - 1;
      default: h = $urandom_range(1, 2 * raster_now + 60);
    endcase
    if (h < 0) h = 0;
    if (h > 4095) h = 4095;
    reach = raster_now + 4;
    case ($urandom_range(0, 9))
      0: y = $urandom_range(0, 4095);
      1: y = h + $urandom_range(0, 3);
      default: begin
        if (h == 0) y = 0;
        else if (reach > h - 1) y = $urandom_range(0, h - 1);
        else if ($urandom_range(0, 2) == 0) y = $urandom_range(0, h - 1);
        else if ($urandom_range(0, 1) == 0) y = $urandom_range(0, reach);
        else y = h - 1 - $urandom_range(0, reach);
      end
    endcase
    if (y > 4095) y = 4095;
    left = $urandom_range(0, 4095);
    if ($urandom_range(0, 4) == 0) right = $urandom_range(0, 4095);
    else right = left + $urandom_range(0, 600);
    if (right > 4095) right = 4095;
    send_row(left, right, $urandom_range(0, 4095), h, y, $urandom, $urandom,
             1'($urandom_range(0, 1)));
  endtask

  initial begin
    int raster_list[8];
    rst_n           = 1'b0;
    start           = 1'b0;
    in_rect_left    = '0;
    in_rect_right   = '0;
    in_rect_top     = '0;
    in_rect_height  = '0;
    in_row_index    = '0;
    in_fill_color   = '0;
    in_border_color = '0;
    in_border_given = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    no_gaps         = 1'b0;
    raster_now      = int'(RASTER_RST);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at the reset raster size: radius 24, border 8.
    send_row(100, 300, 50, 100, 0, 32'h11223344, 32'h55667788, 1'b1);
    send_row(100, 300, 50, 100, 7, 32'h11223344, 32'h55667788, 1'b0);
    send_row(100, 300, 50, 100, 8, 32'hFFFFFFFF, 32'h00000000, 1'b1);
    send_row(100, 300, 50, 100, 20, 32'h00000000, 32'hFFFFFFFF, 1'b1);
    send_row(100, 300, 50, 100, 50, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1);
    send_row(100, 300, 50, 100, 80, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0);
    send_row(100, 300, 50, 100, 91, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1);
    send_row(100, 300, 50, 100, 92, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1);
    send_row(100, 300, 50, 100, 99, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1);
    // Rows at or below the bottom edge give nothing.
    send_row(100, 300, 50, 100, 100, 32'h1, 32'h2, 1'b1);
    send_row(0, 4095, 4095, 0, 4095, 32'h1, 32'h2, 1'b1);
    // A short button falls back to a third of its height.
    send_row(10, 90, 7, 30, 2, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1);
    send_row(10, 90, 7, 30, 4, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1);
    send_row(10, 90, 7, 48, 20, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0);
    send_row(10, 90, 7, 1, 0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1);
    send_row(10, 90, 7, 5, 2, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1);
    // Spans at the screen edges clamp to the coordinate range.
    send_row(0, 4095, 4095, 4095, 4094, 32'hCAFEF00D, 32'h12345678, 1'b1);
    send_row(0, 4095, 0, 4095, 2000, 32'hCAFEF00D, 32'h12345678, 1'b1);
    send_row(0, 3, 0, 200, 30, 32'hCAFEF00D, 32'h12345678, 1'b0);
    send_row(4093, 4095, 0, 200, 30, 32'hCAFEF00D, 32'h12345678, 1'b1);
    // A narrow or reversed rectangle yields empty spans that are still sent.
    send_row(300, 200, 100, 200, 100, 32'hDEADBEEF, 32'h0BADF00D, 1'b1);
    send_row(500, 502, 100, 200, 10, 32'hDEADBEEF, 32'h0BADF00D, 1'b0);
    settle();

    raster_list = '{24, 1, 255, 0, 6, 3, 0, 0};
    raster_list[6] = $urandom_range(1, 255);
    raster_list[7] = $urandom_range(7, 40);
    foreach (raster_list[p]) begin
      if (p > 0) write_raster(raster_list[p]);
      // Every third phase runs back to back so that busy alone paces the sender.
      no_gaps = (p % 3 == 1);
      repeat (ROWS_PER_RS) random_row();
      settle();
    end

    if (mismatch_count == 0 && spans_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
